// ----- design/ppu_pkg.sv -----
// Shared types and constants for the particle pool update block.
// Used by the controller, the datapath and the top level.
`default_nettype none
package ppu_pkg;

	localparam int PARTICLES_DEF = 64;
	localparam int SLOT_W        = 6;
	localparam int CFG_IDX_W     = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EMIT_X   = 3'd0,
		CFG_EMIT_Y   = 3'd1,
		CFG_EMIT_Z   = 3'd2,
		CFG_MAX_LIFE = 3'd3,
		CFG_CAM_X    = 3'd4,
		CFG_CAM_Y    = 3'd5,
		CFG_CAM_Z    = 3'd6
	} ppu_cfg_idx_t;

	localparam logic signed [31:0] EMIT_X_RST   = 32'sd0;
	localparam logic signed [31:0] EMIT_Y_RST   = 32'sd131072;
	localparam logic signed [31:0] EMIT_Z_RST   = 32'sd131072;
	localparam logic [23:0]        MAX_LIFE_RST = 24'd327680;

	// reciprocal of 1000: floor(x/1000) = (x * RECIP_1000) >> SH_1000 for x < 2^32
	localparam logic [29:0] RECIP_1000  = 30'd549755814;
	localparam int          SH_1000     = 39;
	// reciprocal of 20000 with the same trick
	localparam logic [29:0] RECIP_20000 = 30'd879609303;
	localparam int          SH_20000    = 44;

	localparam logic [12:0]        GRAV_NUM     = 13'd4905;
	localparam logic [9:0]         HALF_1000    = 10'd500;
	localparam logic [16:0]        DIR_SCALE    = 17'd98304;
	localparam logic signed [11:0] DIR_CENTRE   = 12'sd1000;
	localparam logic [26:0]        SIZE_OFFS    = 27'd100;
	localparam logic [26:0]        SIZE_ROUND   = 27'd10000;
	localparam logic signed [31:0] SPEED_Y_BASE = 32'sd655360;
	localparam logic [46:0]        DIST_MAX     = 47'h7FFF_FFFF_FFFF;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic adv;
		logic take_idx;
		logic take_zero;
		logic sp_write;
		logic st_load;
		logic st_mul;
		logic st_pos;
		logic dist1;
		logic dist2;
		logic push;
		logic flush;
	} ppu_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cur_alive;
		logic scan_end;
		logic pend_valid;
		logic out_free;
	} ppu_stat_t;

endpackage
`default_nettype wire

// ----- design/ppu_ram.sv -----
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module ppu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- design/ppu_ctrl.sv -----
// Sequencer for the particle pool: spawn search, per-slot step walk, result hand-off.
// Depends on ppu_pkg; drives the datapath through ppu_cmd_t.
`default_nettype none
module ppu_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               kind,
	output logic                    in_ready,
	input  wire ppu_pkg::ppu_stat_t stat,
	output ppu_pkg::ppu_cmd_t       cmd
);
	import ppu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP1, S_PREP2, S_SEARCH, S_SP_WRITE, S_SCAN, S_ST_LD,
		S_ST_MUL, S_ST_POS, S_DIST1, S_DIST2, S_EMIT, S_FLUSH
	} state_t;

	state_t state_q, state_d;
	logic   spawn_q;

	assign in_ready = (state_q == S_IDLE);

	// decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP1;
				end
			end
			S_PREP1: state_d = S_PREP2;
			S_PREP2: state_d = spawn_q ? S_SEARCH : S_SCAN;
			S_SEARCH: begin
				if (!stat.cur_alive) begin
					cmd.take_idx = 1'b1;
					state_d      = S_SP_WRITE;
				end else if (stat.scan_end) begin
					cmd.take_zero = 1'b1;
					state_d       = S_SP_WRITE;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			S_SP_WRITE: begin
				cmd.sp_write = 1'b1;
				state_d      = S_DIST1;
			end
			S_SCAN: begin
				if (stat.cur_alive) begin
					state_d = S_ST_LD;
				end else if (stat.scan_end) begin
					state_d = S_FLUSH;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			S_ST_LD: begin
				cmd.st_load = 1'b1;
				state_d     = S_ST_MUL;
			end
			S_ST_MUL: begin
				cmd.st_mul = 1'b1;
				state_d    = S_ST_POS;
			end
			S_ST_POS: begin
				cmd.st_pos = 1'b1;
				state_d    = S_DIST1;
			end
			S_DIST1: begin
				cmd.dist1 = 1'b1;
				state_d   = S_DIST2;
			end
			S_DIST2: begin
				cmd.dist2 = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				// hold while an older word waits for a full output register
				if (!stat.pend_valid || stat.out_free) begin
					cmd.push = 1'b1;
					if (spawn_q || stat.scan_end) begin
						state_d = S_FLUSH;
					end else begin
						cmd.adv = 1'b1;
						state_d = S_SCAN;
					end
				end
			end
			S_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and item kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			spawn_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				spawn_q <= !kind;
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/ppu_dp.sv -----
// Datapath of the particle pool: registers, slot stores, arithmetic and output staging.
// Depends on ppu_pkg and ppu_ram; steered by ppu_ctrl.
`default_nettype none
module ppu_dp #(
	parameter int PARTICLES = ppu_pkg::PARTICLES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ppu_pkg::ppu_cmd_t                cmd,
	output ppu_pkg::ppu_stat_t                    stat,
	input  wire logic                             kind,
	input  wire logic [10:0]                      rand_x,
	input  wire logic [10:0]                      rand_y,
	input  wire logic [10:0]                      rand_z,
	input  wire logic [9:0]                       rand_size,
	input  wire logic [15:0]                      dt,
	input  wire logic                             cfg_valid,
	input  wire logic [ppu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [31:0]                      cfg_data,
	input  wire logic                             out_ready,
	output logic                                  out_valid,
	output logic                                  from_spawn,
	output logic [ppu_pkg::SLOT_W-1:0]            slot,
	output logic                                  live,
	output logic signed [31:0]                    pos_x,
	output logic signed [31:0]                    pos_y,
	output logic signed [31:0]                    pos_z,
	output logic [15:0]                           part_size,
	output logic [46:0]                           cam_dist,
	output logic                                  last
);
	import ppu_pkg::*;

	localparam int IW = $clog2(PARTICLES);
	localparam logic [IW-1:0] LAST_IDX = IW'(PARTICLES - 1);

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sh7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -50'sh8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// configuration
	logic signed [31:0] emit_q [3];
	logic signed [31:0] cam_q  [3];
	logic [23:0]        max_life_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q[0]  <= EMIT_X_RST;
			emit_q[1]  <= EMIT_Y_RST;
			emit_q[2]  <= EMIT_Z_RST;
			max_life_q <= MAX_LIFE_RST;
			cam_q[0]   <= '0;
			cam_q[1]   <= '0;
			cam_q[2]   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_EMIT_X:   emit_q[0]  <= cfg_data;
				CFG_EMIT_Y:   emit_q[1]  <= cfg_data;
				CFG_EMIT_Z:   emit_q[2]  <= cfg_data;
				CFG_MAX_LIFE: max_life_q <= cfg_data[23:0];
				CFG_CAM_X:    cam_q[0]   <= cfg_data;
				CFG_CAM_Y:    cam_q[1]   <= cfg_data;
				CFG_CAM_Z:    cam_q[2]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// item fields
	logic [10:0] rnd_q [3];
	logic [9:0]  rsize_q;
	logic [15:0] dt_q;
	logic        spawn_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rnd_q[0] <= rand_x;
			rnd_q[1] <= rand_y;
			rnd_q[2] <= rand_z;
			rsize_q  <= rand_size;
			dt_q     <= dt;
			spawn_q  <= !kind;
		end
	end

	// slot walk: index, step count, next-fit start
	logic [IW-1:0]        idx_q, cnt_q, next_free_q, slot_q;
	logic [PARTICLES-1:0] alive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= '0;
		end else if (cmd.take_idx) begin
			next_free_q <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= kind ? '0 : next_free_q;
			cnt_q <= '0;
		end else if (cmd.adv) begin
			idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// precompute spawn speeds, size and gravity in two stages
	logic [27:0]        dnum_s1 [3];
	logic               dneg_s1 [3];
	logic [28:0]        gnum_s1;
	logic [26:0]        snum_s1;
	logic signed [31:0] dir_s2  [3];
	logic [19:0]        grav_s2;
	logic [15:0]        size_s2;

	always_ff @(posedge clk) begin
		logic signed [11:0] diff;
		logic [10:0]        mag;
		logic [57:0]        dprod;
		logic [58:0]        gprod;
		logic [56:0]        sprod;
		for (int a = 0; a < 3; a++) begin
			diff         = $signed({1'b0, rnd_q[a]}) - DIR_CENTRE;
			mag          = diff[11] ? 11'(-diff) : 11'(diff);
			dneg_s1[a]  <= diff[11];
			dnum_s1[a]  <= 28'(mag) * 28'(DIR_SCALE) + 28'(HALF_1000);
			dprod        = 58'(dnum_s1[a]) * 58'(RECIP_1000);
			dir_s2[a]   <= dneg_s1[a] ? -$signed(32'(dprod[57:SH_1000]))
			                          : $signed(32'(dprod[57:SH_1000]));
		end
		gnum_s1 <= 29'(dt_q) * 29'(GRAV_NUM) + 29'(HALF_1000);
		gprod    = 59'(gnum_s1) * 59'(RECIP_1000);
		grav_s2 <= gprod[58:SH_1000];
		snum_s1 <= ((27'(rsize_q) + SIZE_OFFS) << 16) + SIZE_ROUND;
		sprod    = 57'(snum_s1) * 57'(RECIP_20000);
		size_s2 <= 16'(sprod[56:SH_20000]);
	end

	// slot stores
	logic [31:0] life_rd;
	logic [95:0] pos_rd, spd_rd, pos_wd, spd_wd;
	logic [15:0] size_rd;
	logic signed [31:0] life_n_q;
	logic               live_q;
	logic signed [31:0] pos_q  [3];
	logic signed [31:0] spd_q  [3];
	logic signed [48:0] prod_q [3];
	logic signed [31:0] pos_new [3];
	logic [15:0]        size_q;
	logic               life_we, pos_we;

	assign life_we = cmd.st_mul || cmd.sp_write;
	assign pos_we  = cmd.sp_write || (cmd.st_pos && live_q);
	assign pos_wd  = cmd.sp_write ? {emit_q[0], emit_q[1], emit_q[2]}
	                              : {pos_new[0], pos_new[1], pos_new[2]};
	assign spd_wd  = cmd.sp_write ? {dir_s2[0], SPEED_Y_BASE + dir_s2[1], dir_s2[2]}
	                              : {spd_q[0], spd_q[1], spd_q[2]};

	ppu_ram #(.WIDTH(32), .DEPTH(PARTICLES)) u_life (
		.clk(clk), .we(life_we), .waddr(slot_q),
		.wdata(cmd.sp_write ? {8'b0, max_life_q} : life_n_q),
		.raddr(idx_q), .rdata(life_rd)
	);
	ppu_ram #(.WIDTH(96), .DEPTH(PARTICLES)) u_pos (
		.clk(clk), .we(pos_we), .waddr(slot_q), .wdata(pos_wd),
		.raddr(idx_q), .rdata(pos_rd)
	);
	ppu_ram #(.WIDTH(96), .DEPTH(PARTICLES)) u_spd (
		.clk(clk), .we(pos_we), .waddr(slot_q), .wdata(spd_wd),
		.raddr(idx_q), .rdata(spd_rd)
	);
	ppu_ram #(.WIDTH(16), .DEPTH(PARTICLES)) u_size (
		.clk(clk), .we(cmd.sp_write), .waddr(slot_q), .wdata(size_s2),
		.raddr(idx_q), .rdata(size_rd)
	);

	// live flags: a slot without one is free and never read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
		end else if (cmd.sp_write) begin
			alive_q[slot_q] <= (max_life_q != '0);
		end else if (cmd.st_mul) begin
			alive_q[slot_q] <= live_q;
		end
	end

	// integrate position with rounded speed * dt
	always_comb begin
		logic signed [49:0] p, r;
		for (int a = 0; a < 3; a++) begin
			p = 50'(prod_q[a]);
			if (!p[49]) begin
				r = (p + 50'sd32768) >>> 16;
			end else begin
				r = -((-p + 50'sd32768) >>> 16);
			end
			pos_new[a] = sat32(50'(pos_q[a]) + r);
		end
	end

	// per-slot work registers
	logic [48:0] term_q [3];
	logic [46:0] dist_q;

	always_ff @(posedge clk) begin
		logic signed [31:0] life_n;
		logic signed [32:0] dd;
		logic [32:0]        mg;
		logic [65:0]        sq;
		logic [50:0]        sum;
		if (cmd.take_idx) begin
			slot_q <= idx_q;
		end else if (cmd.take_zero) begin
			slot_q <= '0;
		end
		if (cmd.sp_write) begin
			pos_q[0] <= emit_q[0];
			pos_q[1] <= emit_q[1];
			pos_q[2] <= emit_q[2];
			live_q   <= (max_life_q != '0);
			size_q   <= size_s2;
		end
		if (cmd.st_load) begin
			life_n    = $signed(life_rd) - $signed({16'b0, dt_q});
			life_n_q <= life_n;
			live_q   <= (life_n > 0);
			slot_q   <= idx_q;
			pos_q[0] <= pos_rd[95:64];
			pos_q[1] <= pos_rd[63:32];
			pos_q[2] <= pos_rd[31:0];
			spd_q[0] <= spd_rd[95:64];
			spd_q[1] <= sat32(50'($signed(spd_rd[63:32])) - $signed({30'b0, grav_s2}));
			spd_q[2] <= spd_rd[31:0];
			size_q   <= size_rd;
		end
		if (cmd.st_mul) begin
			for (int a = 0; a < 3; a++) begin
				prod_q[a] <= spd_q[a] * $signed({1'b0, dt_q});
			end
		end
		if (cmd.st_pos && live_q) begin
			for (int a = 0; a < 3; a++) begin
				pos_q[a] <= pos_new[a];
			end
		end
		if (cmd.dist1) begin
			for (int a = 0; a < 3; a++) begin
				dd         = 33'(pos_q[a]) - 33'(cam_q[a]);
				mg         = dd[32] ? 33'(-dd) : 33'(dd);
				sq         = 66'(mg) * 66'(mg);
				term_q[a] <= sq[64:16];
			end
		end
		if (cmd.dist2) begin
			sum = 51'(term_q[0]) + 51'(term_q[1]) + 51'(term_q[2]);
			if (!live_q) begin
				dist_q <= '0;
			end else if (sum > 51'(DIST_MAX)) begin
				dist_q <= DIST_MAX;
			end else begin
				dist_q <= sum[46:0];
			end
		end
	end

	// hold one word back so the last one of an item can be marked
	logic                 pend_valid_q, out_valid_q;
	logic                 p_spawn_q, p_live_q;
	logic [SLOT_W-1:0]    p_slot_q;
	logic signed [31:0]   p_pos_q [3];
	logic [15:0]          p_size_q;
	logic [46:0]          p_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.push) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if ((cmd.push && pend_valid_q) || cmd.flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.push && pend_valid_q) || cmd.flush) begin
			from_spawn <= p_spawn_q;
			slot       <= p_slot_q;
			live       <= p_live_q;
			pos_x      <= p_pos_q[0];
			pos_y      <= p_pos_q[1];
			pos_z      <= p_pos_q[2];
			part_size  <= p_size_q;
			cam_dist   <= p_dist_q;
			last       <= cmd.flush;
		end
		if (cmd.push) begin
			p_spawn_q  <= spawn_q;
			p_slot_q   <= SLOT_W'(slot_q);
			p_live_q   <= live_q;
			p_pos_q[0] <= pos_q[0];
			p_pos_q[1] <= pos_q[1];
			p_pos_q[2] <= pos_q[2];
			p_size_q   <= size_q;
			p_dist_q   <= dist_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign stat.cur_alive  = alive_q[idx_q];
	assign stat.scan_end   = (cnt_q == LAST_IDX);
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = !out_valid_q || out_ready;
endmodule
`default_nettype wire

// ----- design/particle_pool_update.sv -----
// Particle pool update. A spawn runs a next-fit search from the last slot taken, one slot
// a cycle, and yields one word. A step walks every slot: free slots are skipped one a cycle,
// live slots go through a single read-modify-write datapath (load, multiply, position,
// distance in two steps, emit) and one store port per field. One item at a time.
// Reset clears all slots to free, the next-fit start to slot 0 and the registers to
// their defaults; no clearing pass is needed.
`default_nettype none
module particle_pool_update #(
	parameter int PARTICLES = ppu_pkg::PARTICLES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          kind,
	input  wire logic [10:0]                   rand_x,
	input  wire logic [10:0]                   rand_y,
	input  wire logic [10:0]                   rand_z,
	input  wire logic [9:0]                    rand_size,
	input  wire logic [15:0]                   dt,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ppu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               from_spawn,
	output logic [ppu_pkg::SLOT_W-1:0]         slot,
	output logic                               live,
	output logic signed [31:0]                 pos_x,
	output logic signed [31:0]                 pos_y,
	output logic signed [31:0]                 pos_z,
	output logic [15:0]                        part_size,
	output logic [46:0]                        cam_dist,
	output logic                               last
);
	import ppu_pkg::*;

	ppu_cmd_t  cmd;
	ppu_stat_t stat;

	// registers take a word in any cycle
	assign cfg_ready = 1'b1;

	ppu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .kind(kind),
		.in_ready(in_ready), .stat(stat), .cmd(cmd)
	);

	ppu_dp #(.PARTICLES(PARTICLES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .kind(kind),
		.rand_x(rand_x), .rand_y(rand_y), .rand_z(rand_z), .rand_size(rand_size),
		.dt(dt), .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_ready(out_ready), .out_valid(out_valid), .from_spawn(from_spawn),
		.slot(slot), .live(live), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.part_size(part_size), .cam_dist(cam_dist), .last(last)
	);
endmodule
`default_nettype wire

// ----- tb/sv/tb_particle_pool_update.sv -----
// Self-checking testbench for particle_pool_update: directed table, then random phases.
// Depends on ppu_pkg (register indexes, reset values) and the particle_pool_update RTL.
`timescale 1ns / 1ps
module tb_particle_pool_update;
	import ppu_pkg::*;

	localparam int      NSLOT    = 64;
	localparam int      DRAIN    = 600;
	localparam longint  LIMIT    = 5000000;
	localparam longint  Q16_ONE  = 65536;
	localparam logic [63:0] DIST_SAT = 64'h7FFF_FFFF_FFFF;

	typedef struct {
		logic        from_spawn;
		logic [5:0]  slot;
		logic        live;
		logic [31:0] px, py, pz;
		logic [15:0] size;
		logic [46:0] cam_sq;
		logic        last;
	} particle_word_t;

	typedef struct {
		bit          kind;
		bit [10:0]   rx, ry, rz;
		bit [9:0]    rs;
		bit [15:0]   dt;
		bit          typed;
		bit [5:0]    slot;
		bit [15:0]   size;
		bit [46:0]   cam_sq;
	} stim_row_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready;
	logic kind = 0;
	logic [10:0] rand_x = 0, rand_y = 0, rand_z = 0;
	logic [9:0] rand_size = 0;
	logic [15:0] dt = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = 0;
	logic out_valid, out_ready = 1;
	logic from_spawn, live, last;
	logic [SLOT_W-1:0] slot;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic [15:0] part_size;
	logic [46:0] cam_dist;

	// pool image kept in step with the block
	longint emit_pos[3], cam_pos[3], life_max;
	longint life_of[NSLOT];
	longint pos_of[NSLOT][3];
	longint speed_of[NSLOT][3];
	int unsigned size_of[NSLOT];
	int unsigned search_from;

	particle_word_t pending_words[$];
	int errors = 0;
	longint cycles = 0;
	bit calm = 0;
	int stall_left = 0;

	particle_pool_update uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// abandon a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("particle_pool_update: mismatch");
			$finish;
		end
	end

	// hold off the result side at random
	always @(negedge clk) begin
		if (calm) begin
			out_ready = 1;
		end else if (stall_left > 0) begin
			out_ready = 0;
			stall_left--;
		end else begin
			out_ready = 1;
			if ($urandom_range(0, 7) == 0)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
				                                         : $urandom_range(1, 3);
		end
	end

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("word field %s: got %h want %h", field, got, want);
		errors++;
	endtask

	function automatic longint round_div(longint n, longint d);
		if (n >= 0) return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint spread(logic [10:0] r);
		return round_div((longint'(r) - 1000) * 98304, 1000);
	endfunction

	function automatic logic [46:0] camera_range(int s);
		logic [63:0] sum, m;
		longint d;
		sum = 0;
		for (int a = 0; a < 3; a++) begin
			d = pos_of[s][a] - cam_pos[a];
			m = (d < 0) ? -d : d;
			sum += (m * m) >> 16;
		end
		return (sum > DIST_SAT) ? DIST_SAT[46:0] : sum[46:0];
	endfunction

	function automatic particle_word_t slot_word(bit spawn, int s, bit alive);
		particle_word_t w;
		w.from_spawn = spawn;
		w.slot = 6'(s);
		w.live = alive;
		w.px = 32'(pos_of[s][0]);
		w.py = 32'(pos_of[s][1]);
		w.pz = 32'(pos_of[s][2]);
		w.size = 16'(size_of[s]);
		w.cam_sq = alive ? camera_range(s) : '0;
		w.last = 0;
		return w;
	endfunction

	// advance the pool image by one item and queue the words it yields
	task automatic predict_pool(bit k, logic [10:0] rx, logic [10:0] ry, logic [10:0] rz,
	                            logic [9:0] rs, logic [15:0] step_dt);
		int s, n;
		bit alive;
		particle_word_t w;
		if (!k) begin
			s = 0;
			for (int i = 0; i < NSLOT; i++) begin
				int j;
				j = (search_from + i) % NSLOT;
				if (life_of[j] <= 0) begin
					s = j;
					search_from = j;
					break;
				end
			end
			life_of[s] = life_max;
			for (int a = 0; a < 3; a++) pos_of[s][a] = emit_pos[a];
			speed_of[s][0] = spread(rx);
			speed_of[s][1] = 10 * Q16_ONE + spread(ry);
			speed_of[s][2] = spread(rz);
			size_of[s] = ((rs + 100) * 65536 + 10000) / 20000;
			w = slot_word(1, s, life_max > 0);
			w.last = 1;
			pending_words = {pending_words, w};
		end else begin
			n = 0;
			for (int i = 0; i < NSLOT; i++) begin
				if (life_of[i] <= 0) continue;
				life_of[i] -= step_dt;
				alive = life_of[i] > 0;
				if (alive) begin
					speed_of[i][1] = clamp32(speed_of[i][1] - round_div(step_dt * 4905, 1000));
					for (int a = 0; a < 3; a++)
						pos_of[i][a] = clamp32(pos_of[i][a]
						               + round_div(speed_of[i][a] * step_dt, Q16_ONE));
				end
				w = slot_word(0, i, alive);
				pending_words = {pending_words, w};
				n++;
			end
			if (n > 0) pending_words[$].last = 1;
		end
	endtask

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				report("unexpected slot", 64'(slot), 64'd0);
			end else begin
				particle_word_t w;
				w = pending_words.pop_front();
				if (from_spawn !== w.from_spawn)
					report("from_spawn", 64'(from_spawn), 64'(w.from_spawn));
				if (slot !== w.slot)        report("slot", 64'(slot), 64'(w.slot));
				if (live !== w.live)        report("live", 64'(live), 64'(w.live));
				if (pos_x !== w.px)         report("pos_x", 64'(pos_x), 64'(w.px));
				if (pos_y !== w.py)         report("pos_y", 64'(pos_y), 64'(w.py));
				if (pos_z !== w.pz)         report("pos_z", 64'(pos_z), 64'(w.pz));
				if (part_size !== w.size)   report("part_size", 64'(part_size), 64'(w.size));
				if (cam_dist !== w.cam_sq)  report("cam_dist", 64'(cam_dist), 64'(w.cam_sq));
				if (last !== w.last)        report("last", 64'(last), 64'(w.last));
			end
		end
	end

	// send one item, with a random gap ahead of it
	task automatic send_item(bit k, logic [10:0] rx, logic [10:0] ry, logic [10:0] rz,
	                         logic [9:0] rs, logic [15:0] step_dt);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		kind = k; rand_x = rx; rand_y = ry; rand_z = rz; rand_size = rs; dt = step_dt;
		in_valid = 1;
		// ready is settled at the falling edge; the word goes at the next rising one
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		predict_pool(k, rx, ry, rz, rs, step_dt);
	endtask

	// drop valid, then wait out every word and any silent step still running
	task automatic drain_pool;
		@(negedge clk);
		in_valid = 0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(ppu_cfg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1;
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		case (idx)
			CFG_EMIT_X:   emit_pos[0] = longint'(signed'(value));
			CFG_EMIT_Y:   emit_pos[1] = longint'(signed'(value));
			CFG_EMIT_Z:   emit_pos[2] = longint'(signed'(value));
			CFG_MAX_LIFE: life_max = value[23:0];
			CFG_CAM_X:    cam_pos[0] = longint'(signed'(value));
			CFG_CAM_Y:    cam_pos[1] = longint'(signed'(value));
			CFG_CAM_Z:    cam_pos[2] = longint'(signed'(value));
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic write_all(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
	                         logic [23:0] ml, logic [31:0] cx, logic [31:0] cy,
	                         logic [31:0] cz);
		write_reg(CFG_EMIT_X, ex);
		write_reg(CFG_EMIT_Y, ey);
		write_reg(CFG_EMIT_Z, ez);
		write_reg(CFG_MAX_LIFE, {8'd0, ml});
		write_reg(CFG_CAM_X, cx);
		write_reg(CFG_CAM_Y, cy);
		write_reg(CFG_CAM_Z, cz);
	endtask

	// random items: spawn share in percent, step size mostly up to dt_top
	task automatic random_items(int count, int spawn_pct, int dt_top);
		logic [15:0] d;
		for (int i = 0; i < count; i++) begin
			d = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
			                                : 16'($urandom_range(0, dt_top));
			send_item($urandom_range(0, 99) >= spawn_pct,
			          11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
			          11'($urandom_range(0, 2047)), 10'($urandom_range(0, 1023)), d);
		end
	endtask

	stim_row_t opening[15] = '{
		'{0, 11'd0,    11'd0,    11'd0,    10'd0,    16'd0,     1, 6'd0, 16'd328,  47'd524288},
		'{0, 11'd2047, 11'd2047, 11'd2047, 10'd1023, 16'd0,     1, 6'd1, 16'd3680, 47'd524288},
		'{0, 11'd1000, 11'd1000, 11'd1000, 10'd999,  16'd0,     1, 6'd2, 16'd3601, 47'd524288},
		'{1, 11'd0,    11'd0,    11'd0,    10'd0,    16'd0,     0, 6'd0, 16'd0,    47'd0},
		'{1, 11'd0,    11'd0,    11'd0,    10'd0,    16'd1049,  0, 6'd0, 16'd0,    47'd0},
		'{0, 11'd1999, 11'd0,    11'd1999, 10'd500,  16'd0,     0, 6'd0, 16'd0,    47'd0},
		'{1, 11'd0,    11'd0,    11'd0,    10'd0,    16'd65535, 0, 6'd0, 16'd0,    47'd0},
		'{1, 11'd0,    11'd0,    11'd0,    10'd0,    16'd65535, 0, 6'd0, 16'd0,    47'd0},
		'{1, 11'd0,    11'd0,    11'd0,    10'd0,    16'd65535, 0, 6'd0, 16'd0,    47'd0},
		'{1, 11'd0,    11'd0,    11'd0,    10'd0,    16'd65535, 0, 6'd0, 16'd0,    47'd0},
		'{1, 11'd0,    11'd0,    11'd0,    10'd0,    16'd65535, 0, 6'd0, 16'd0,    47'd0},
		'{1, 11'd0,    11'd0,    11'd0,    10'd0,    16'd1,     0, 6'd0, 16'd0,    47'd0},
		'{0, 11'd123,  11'd1876, 11'd5,    10'd1,    16'd0,     0, 6'd0, 16'd0,    47'd0},
		'{1, 11'd0,    11'd0,    11'd0,    10'd0,    16'd0,     0, 6'd0, 16'd0,    47'd0},
		'{1, 11'd0,    11'd0,    11'd0,    10'd0,    16'd16,    0, 6'd0, 16'd0,    47'd0}
	};

	initial begin
		particle_word_t w;
		emit_pos = '{EMIT_X_RST, EMIT_Y_RST, EMIT_Z_RST};
		cam_pos = '{0, 0, 0};
		life_max = MAX_LIFE_RST;
		search_from = 0;
		for (int i = 0; i < NSLOT; i++) begin
			life_of[i] = -Q16_ONE;
			size_of[i] = 0;
			for (int a = 0; a < 3; a++) begin
				pos_of[i][a] = 0;
				speed_of[i][a] = 0;
			end
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// walk the opening table under reset settings
		foreach (opening[r]) begin
			send_item(opening[r].kind, opening[r].rx, opening[r].ry, opening[r].rz,
			          opening[r].rs, opening[r].dt);
			if (opening[r].typed) begin
				w = '{1, opening[r].slot, 1, 32'd0, 32'd131072, 32'd131072,
				      opening[r].size, opening[r].cam_sq, 1};
				pending_words[$] = w;
			end
		end
		drain_pool();

		// far corners with long life: fill the pool past full, saturate positions
		write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 24'hFF_FFFF,
		          32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		random_items(120, 80, 65535);
		drain_pool();

		// zero life: spawns come back dead
		write_all($urandom, $urandom, $urandom, 24'h0, $urandom, $urandom, $urandom);
		random_items(30, 60, 65535);
		drain_pool();

		// random settings, no idling on either side
		calm = 1;
		write_all($urandom, $urandom, $urandom, 24'd200000, $urandom, $urandom, $urandom);
		random_items(100, 50, 20000);
		drain_pool();
		calm = 0;

		// near the origin, short frames
		write_all($urandom_range(0, 400000), $urandom_range(0, 400000), 32'hFFFF_0000,
		          24'd327680, 32'h0, 32'h0001_0000, $urandom_range(0, 200000));
		random_items(100, 40, 4000);
		drain_pool();

		if (errors == 0)
			$display("particle_pool_update: match");
		else
			$display("particle_pool_update: mismatch");
		$finish;
	end

endmodule

// ----- particle_pool_update.f -----
design/ppu_pkg.sv
design/ppu_ram.sv
design/ppu_ctrl.sv
design/ppu_dp.sv
design/particle_pool_update.sv
tb/sv/tb_particle_pool_update.sv
